>>> sv/rsrb_pkg.sv
// shared types, codes and helpers for the rtp sequence reorder buffer
package rsrb_pkg;

   // result status codes
   localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
   localparam logic [2:0] STATUS_LATE     = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_INVALID  = 3'd3;
   localparam logic [2:0] STATUS_TICK     = 3'd4;

   // request kinds
   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // register indexes
   localparam logic REG_MAX_DEPTH   = 1'b0;
   localparam logic REG_MAX_WAIT_MS = 1'b1;

   // register reset values
   localparam logic [5:0]  MAX_DEPTH_RESET   = 6'd32;
   localparam logic [15:0] MAX_WAIT_RESET    = 16'd50;
   // a depth register of zero means this many entries
   localparam logic [6:0]  DEPTH_ZERO_MEANS  = 7'd64;
   localparam logic [15:0] HALF_RANGE        = 16'h8000;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_CHAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // operation waiting on a table scan
   typedef enum logic [2:0] {
      OP_TICK  = 3'b001,
      OP_FULL  = 3'b010,
      OP_STORE = 3'b100
   } op_type;

   // status of the table scan unit
   typedef struct packed {
      logic done;
      logic match_found;
      logic near_found;
      logic free_found;
   } scan_flags_type;

   // saturating increment
   function automatic logic [31:0] sat_inc(input logic [31:0] a);
      logic [32:0] s;
      s = {1'b0, a} + 33'd1;
      sat_inc = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // saturating add of a 16-bit amount
   function automatic logic [31:0] sat_add16(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      sat_add16 = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

>>> sv/rtp_sequence_reorder_buffer.sv
// top level of the rtp sequence reorder buffer: sequencer, state and ports
//
//  channel  | direction | handshake          | contents
//  req_     | in        | req_valid/req_stall | packet or tick item
//  rsp_     | out       | rsp_valid/rsp_stall | result items, rsp_last ends an item
//  csr_     | in/out    | apb write/read      | max_depth, max_wait_ms
//
// a table scan reads every entry in turn, through the read and compare registers, before
// the sequencer acts on it. late and invalid packets need no scan; ticks, held and rejected
// packets take one scan, as does an in-order packet; a gap skip adds a second scan, and each
// chained delivery adds one more scan.
// reset clears control state and valid bits at once; no clearing pass.
// a stalled result holds the sequencer; req_stall is high until the last result is loaded into the result register.
module rtp_sequence_reorder_buffer #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_seq,
   input  logic [15:0] req_payload_handle,
   input  logic [15:0] req_payload_size,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_delivery,
   output logic [15:0] rsp_out_seq,
   output logic [15:0] rsp_out_handle,
   output logic [15:0] rsp_out_size,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_next_expected,
   output logic [5:0]  rsp_buffered_count,
   output logic [31:0] rsp_reorder_total,
   output logic [31:0] rsp_late_total,
   output logic [31:0] rsp_drop_total,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rsrb_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [6:0] DEPTH_MAX = 7'(TABLE_DEPTH);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [15:0]      expected_ff, expected_in;
   logic             have_ff, have_in;
   logic             timer_ff, timer_in;
   logic [31:0]      start_ff, start_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [31:0]      reorder_ff, reorder_in;
   logic [31:0]      late_ff, late_in;
   logic [31:0]      drop_ff, drop_in;
   logic [5:0]       max_depth_ff, max_depth_in;
   logic [15:0]      max_wait_ff, max_wait_in;
   logic [31:0]      now_ff, now_in;
   logic [15:0]      seq_ff, seq_in, hnd_ff, hnd_in, siz_ff, siz_in;
   logic             pend_dlv_ff, pend_dlv_in;
   logic [15:0]      pend_seq_ff, pend_seq_in;
   logic [15:0]      pend_hnd_ff, pend_hnd_in;
   logic [15:0]      pend_siz_ff, pend_siz_in;
   logic [2:0]       status_ff, status_in;
   logic             last_ff, last_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             r_dlv_ff;
   logic [15:0]      r_seq_ff, r_hnd_ff, r_siz_ff, r_next_ff;
   logic [2:0]       r_status_ff;
   logic [5:0]       r_count_ff;
   logic [31:0]      r_reorder_ff, r_late_ff, r_drop_ff;
   logic             r_last_ff;
   logic             load_rsp;
   logic             out_free;

   // scan unit connections
   scan_flags_type   sflags;
   logic             scan_start;
   logic [15:0]      scan_key;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [IW-1:0]    match_idx, near_idx, free_idx;
   logic [15:0]      match_seq, match_handle, match_size, near_seq;

   logic             accept;
   logic [15:0]      req_d;
   logic [6:0]       depth_lim;
   logic             table_full;
   logic             csr_write;
   logic [15:0]      skip_d;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_d    = req_seq - expected_ff;
   assign skip_d   = near_seq - expected_ff;

   // effective depth limit
   always_comb begin
      depth_lim = (max_depth_ff == 6'd0) ? DEPTH_ZERO_MEANS : {1'b0, max_depth_ff};
      if (depth_lim > DEPTH_MAX) begin
         depth_lim = DEPTH_MAX;
      end
   end
   assign table_full = (7'(count_ff) >= depth_lim);

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      case (csr_paddr[2])
         REG_MAX_DEPTH:   csr_prdata = {26'd0, max_depth_ff};
         REG_MAX_WAIT_MS: csr_prdata = {16'd0, max_wait_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      expected_in  = expected_ff;
      have_in      = have_ff;
      timer_in     = timer_ff;
      start_in     = start_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      reorder_in   = reorder_ff;
      late_in      = late_ff;
      drop_in      = drop_ff;
      max_depth_in = max_depth_ff;
      max_wait_in  = max_wait_ff;
      now_in       = now_ff;
      seq_in       = seq_ff;
      hnd_in       = hnd_ff;
      siz_in       = siz_ff;
      pend_dlv_in  = pend_dlv_ff;
      pend_seq_in  = pend_seq_ff;
      pend_hnd_in  = pend_hnd_ff;
      pend_siz_in  = pend_siz_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      scan_start   = 1'b0;
      scan_key     = expected_ff;
      wr_en        = 1'b0;
      wr_addr      = free_idx;
      load_rsp     = 1'b0;

      // configuration writes
      if (csr_write) begin
         case (csr_paddr[2])
            REG_MAX_DEPTH:   max_depth_in = csr_pwdata[5:0];
            REG_MAX_WAIT_MS: max_wait_in  = csr_pwdata[15:0];
            default:         max_depth_in = max_depth_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seq_in      = req_seq;
               hnd_in      = req_payload_handle;
               siz_in      = req_payload_size;
               now_in      = req_now_ms;
               pend_dlv_in = 1'b0;
               pend_seq_in = 16'd0;
               pend_hnd_in = 16'd0;
               pend_siz_in = 16'd0;
               last_in     = 1'b1;
               if (req_type == REQ_TICK) begin
                  status_in  = STATUS_TICK;
                  op_in      = OP_TICK;
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end else if (req_payload_size == 16'd0) begin
                  status_in = STATUS_INVALID;
                  state_in  = ST_EMIT;
               end else if (!have_ff || req_d == 16'd0) begin
                  // in-order packet goes straight out, then look for the next one
                  status_in   = STATUS_ACCEPTED;
                  have_in     = 1'b1;
                  expected_in = req_seq + 16'd1;
                  pend_dlv_in = 1'b1;
                  pend_seq_in = req_seq;
                  pend_hnd_in = req_payload_handle;
                  pend_siz_in = req_payload_size;
                  scan_key    = req_seq + 16'd1;
                  scan_start  = 1'b1;
                  state_in    = ST_CHAIN;
               end else if (req_d >= HALF_RANGE) begin
                  status_in = STATUS_LATE;
                  late_in   = sat_inc(late_ff);
                  state_in  = ST_EMIT;
               end else if (table_full) begin
                  status_in  = STATUS_FULL;
                  op_in      = OP_FULL;
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end else begin
                  status_in  = STATUS_ACCEPTED;
                  op_in      = OP_STORE;
                  scan_key   = req_seq;
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sflags.done) begin
               state_in = ST_EMIT;
               case (op_ff)
                  OP_TICK: begin
                     if (!have_ff || !sflags.near_found) begin
                        timer_in = 1'b0;
                     end else if (near_seq == expected_ff) begin
                        timer_in = 1'b0;
                     end else if (!timer_ff) begin
                        timer_in = 1'b1;
                        start_in = now_ff;
                     end else if ((now_ff - start_ff) >= {16'd0, max_wait_ff}) begin
                        // gap timed out: skip to the nearest held number
                        if (skip_d < HALF_RANGE) begin
                           drop_in = sat_add16(drop_ff, skip_d);
                        end
                        expected_in = near_seq;
                        timer_in    = 1'b0;
                        scan_key    = near_seq;
                        scan_start  = 1'b1;
                        state_in    = ST_CHAIN;
                     end
                  end
                  OP_FULL: begin
                     drop_in  = sat_inc(drop_ff);
                     timer_in = 1'b0;
                     if (sflags.near_found) begin
                        valid_in[near_idx] = 1'b0;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_STORE: begin
                     if (sflags.match_found) begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx;
                     end else if (sflags.free_found) begin
                        wr_en    = 1'b1;
                        wr_addr  = free_idx;
                        valid_in[free_idx] = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     reorder_in = sat_inc(reorder_ff);
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_CHAIN: begin
            if (sflags.done) begin
               last_in = !sflags.match_found;
               if (pend_dlv_ff && (count_ff == '0 || sflags.match_found)) begin
                  timer_in = 1'b0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // release the held entry that is now in order
                  valid_in[match_idx] = 1'b0;
                  count_in    = count_ff - 1'b1;
                  expected_in = match_seq + 16'd1;
                  pend_dlv_in = 1'b1;
                  pend_seq_in = match_seq;
                  pend_hnd_in = match_handle;
                  pend_siz_in = match_size;
                  scan_key    = match_seq + 16'd1;
                  scan_start  = 1'b1;
                  state_in    = ST_CHAIN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_TICK;
         expected_ff  <= 16'd0;
         have_ff      <= 1'b0;
         timer_ff     <= 1'b0;
         start_ff     <= 32'd0;
         valid_ff     <= '0;
         count_ff     <= '0;
         reorder_ff   <= 32'd0;
         late_ff      <= 32'd0;
         drop_ff      <= 32'd0;
         max_depth_ff <= MAX_DEPTH_RESET;
         max_wait_ff  <= MAX_WAIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         expected_ff  <= expected_in;
         have_ff      <= have_in;
         timer_ff     <= timer_in;
         start_ff     <= start_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         reorder_ff   <= reorder_in;
         late_ff      <= late_in;
         drop_ff      <= drop_in;
         max_depth_ff <= max_depth_in;
         max_wait_ff  <= max_wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      seq_ff      <= seq_in;
      hnd_ff      <= hnd_in;
      siz_ff      <= siz_in;
      pend_dlv_ff <= pend_dlv_in;
      pend_seq_ff <= pend_seq_in;
      pend_hnd_ff <= pend_hnd_in;
      pend_siz_ff <= pend_siz_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
   end

   // result payload, loaded from the state after each step
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         r_dlv_ff     <= pend_dlv_ff;
         r_seq_ff     <= pend_seq_ff;
         r_hnd_ff     <= pend_hnd_ff;
         r_siz_ff     <= pend_siz_ff;
         r_status_ff  <= status_ff;
         r_next_ff    <= expected_ff;
         r_count_ff   <= 6'(count_ff);
         r_reorder_ff <= reorder_ff;
         r_late_ff    <= late_ff;
         r_drop_ff    <= drop_ff;
         r_last_ff    <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_delivery    = r_dlv_ff;
   assign rsp_out_seq        = r_seq_ff;
   assign rsp_out_handle     = r_hnd_ff;
   assign rsp_out_size       = r_siz_ff;
   assign rsp_status         = r_status_ff;
   assign rsp_next_expected  = r_next_ff;
   assign rsp_buffered_count = r_count_ff;
   assign rsp_reorder_total  = r_reorder_ff;
   assign rsp_late_total     = r_late_ff;
   assign rsp_drop_total     = r_drop_ff;
   assign rsp_last           = r_last_ff;

   // table memory and scan unit
   rsrb_scan #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IW(IW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .key         (scan_key),
      .ref_seq     (expected_ff),
      .valid_vec   (valid_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_seq      (seq_ff),
      .wr_handle   (hnd_ff),
      .wr_size     (siz_ff),
      .flags       (sflags),
      .match_idx   (match_idx),
      .match_seq   (match_seq),
      .match_handle(match_handle),
      .match_size  (match_size),
      .near_idx    (near_idx),
      .near_seq    (near_seq),
      .free_idx    (free_idx)
   );

endmodule

>>> sv/rsrb_scan.sv
// table memory and sequential scan unit: match, nearest ahead and first free slot
module rsrb_scan #(
   parameter int TABLE_DEPTH = 32,
   parameter int IW = $clog2(TABLE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [15:0]                 key,
   input  logic [15:0]                 ref_seq,
   input  logic [TABLE_DEPTH-1:0]      valid_vec,
   input  logic                        wr_en,
   input  logic [IW-1:0]               wr_addr,
   input  logic [15:0]                 wr_seq,
   input  logic [15:0]                 wr_handle,
   input  logic [15:0]                 wr_size,
   output rsrb_pkg::scan_flags_type    flags,
   output logic [IW-1:0]               match_idx,
   output logic [15:0]                 match_seq,
   output logic [15:0]                 match_handle,
   output logic [15:0]                 match_size,
   output logic [IW-1:0]               near_idx,
   output logic [15:0]                 near_seq,
   output logic [IW-1:0]               free_idx
);
   import rsrb_pkg::*;

   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   // entry memories
   logic [15:0] seq_mem [TABLE_DEPTH];
   logic [15:0] hnd_mem [TABLE_DEPTH];
   logic [15:0] siz_mem [TABLE_DEPTH];

   logic          busy_ff, busy_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [15:0]   rd_seq_ff, rd_hnd_ff, rd_siz_ff;
   logic [15:0]   key_ff, key_in, ref_ff, ref_in;
   logic          done_ff, done_in;
   logic          match_found_ff, match_found_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic [15:0]   match_seq_ff, match_seq_in;
   logic [15:0]   match_hnd_ff, match_hnd_in;
   logic [15:0]   match_siz_ff, match_siz_in;
   logic          near_found_ff, near_found_in;
   logic [IW-1:0] near_idx_ff, near_idx_in;
   logic [15:0]   near_seq_ff, near_seq_in;
   logic [15:0]   near_d_ff, near_d_in;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [15:0]   cur_d;
   logic          cur_valid;

   // memory write and registered read at the scan address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem[wr_addr] <= wr_seq;
         hnd_mem[wr_addr] <= wr_handle;
         siz_mem[wr_addr] <= wr_size;
      end
      rd_seq_ff <= seq_mem[rd_idx_ff];
      rd_hnd_ff <= hnd_mem[rd_idx_ff];
      rd_siz_ff <= siz_mem[rd_idx_ff];
   end

   assign cur_d     = rd_seq_ff - ref_ff;
   assign cur_valid = valid_vec[cmp_idx_ff];

   // address counter and compare stage
   always_comb begin
      busy_in        = busy_ff;
      rd_idx_in      = rd_idx_ff;
      cmp_vld_in     = busy_ff;
      cmp_idx_in     = rd_idx_ff;
      key_in         = key_ff;
      ref_in         = ref_ff;
      done_in        = 1'b0;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_seq_in   = match_seq_ff;
      match_hnd_in   = match_hnd_ff;
      match_siz_in   = match_siz_ff;
      near_found_in  = near_found_ff;
      near_idx_in    = near_idx_ff;
      near_seq_in    = near_seq_ff;
      near_d_in      = near_d_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      if (busy_ff) begin
         if (rd_idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end
      if (cmp_vld_ff) begin
         if (cmp_idx_ff == LAST_IDX) begin
            done_in = 1'b1;
         end
         if (cur_valid) begin
            if (!match_found_ff && rd_seq_ff == key_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = cmp_idx_ff;
               match_seq_in   = rd_seq_ff;
               match_hnd_in   = rd_hnd_ff;
               match_siz_in   = rd_siz_ff;
            end
            if (!near_found_ff || cur_d < near_d_ff) begin
               near_found_in = 1'b1;
               near_idx_in   = cmp_idx_ff;
               near_seq_in   = rd_seq_ff;
               near_d_in     = cur_d;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
      end
      // a new scan clears the results
      if (start) begin
         busy_in        = 1'b1;
         rd_idx_in      = '0;
         cmp_vld_in     = 1'b0;
         key_in         = key;
         ref_in         = ref_seq;
         done_in        = 1'b0;
         match_found_in = 1'b0;
         near_found_in  = 1'b0;
         free_found_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         rd_idx_ff      <= '0;
         cmp_vld_ff     <= 1'b0;
         done_ff        <= 1'b0;
         match_found_ff <= 1'b0;
         near_found_ff  <= 1'b0;
         free_found_ff  <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         rd_idx_ff      <= rd_idx_in;
         cmp_vld_ff     <= cmp_vld_in;
         done_ff        <= done_in;
         match_found_ff <= match_found_in;
         near_found_ff  <= near_found_in;
         free_found_ff  <= free_found_in;
      end
      cmp_idx_ff   <= cmp_idx_in;
      key_ff       <= key_in;
      ref_ff       <= ref_in;
      match_idx_ff <= match_idx_in;
      match_seq_ff <= match_seq_in;
      match_hnd_ff <= match_hnd_in;
      match_siz_ff <= match_siz_in;
      near_idx_ff  <= near_idx_in;
      near_seq_ff  <= near_seq_in;
      near_d_ff    <= near_d_in;
      free_idx_ff  <= free_idx_in;
   end

   assign flags.done        = done_ff;
   assign flags.match_found = match_found_ff;
   assign flags.near_found  = near_found_ff;
   assign flags.free_found  = free_found_ff;
   assign match_idx    = match_idx_ff;
   assign match_seq    = match_seq_ff;
   assign match_handle = match_hnd_ff;
   assign match_size   = match_siz_ff;
   assign near_idx     = near_idx_ff;
   assign near_seq     = near_seq_ff;
   assign free_idx     = free_idx_ff;

endmodule

>>> sv/rsrb_checker.sv
// port checker for the rtp sequence reorder buffer and its bind
module rsrb_checker #(
   parameter int TABLE_DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_is_delivery,
   input logic [15:0] rsp_out_seq,
   input logic [15:0] rsp_out_handle,
   input logic [15:0] rsp_out_size,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_next_expected,
   input logic [5:0]  rsp_buffered_count,
   input logic        rsp_last
);
   import rsrb_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a delivery moves the expected number just past it
   a_dlv_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_delivery |-> rsp_next_expected == rsp_out_seq + 16'd1)
      else $error("expected number does not follow delivery");

   // non-delivery results carry no packet
   a_no_dlv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_delivery |->
         rsp_out_seq == 16'd0 && rsp_out_handle == 16'd0 && rsp_out_size == 16'd0)
      else $error("packet fields set without delivery");

   // held count never exceeds the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_buffered_count <= 6'(TABLE_DEPTH))
      else $error("held count beyond table size");

   // late and invalid packets give a single result
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_LATE || rsp_status == STATUS_INVALID) |-> rsp_last)
      else $error("late or invalid item not single result");

endmodule

bind rtp_sequence_reorder_buffer rsrb_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_rsrb_checker (.*);
